// ----- sv/wfpa_pkg.sv -----
// Package for the worst-fit partition allocator.
// Holds sizing constants, operation/status/config codes, and the
// command/status structs between controller and datapath. No dependencies.
package wfpa_pkg;

    localparam int MAX_PARTS = 64;
    localparam int MAX_PROCS = 256;
    localparam int SIZE_BITS = 16;

    localparam int PART_BITS = $clog2(MAX_PARTS);
    localparam int CNT_BITS  = $clog2(MAX_PARTS + 1);
    localparam int PROC_BITS = $clog2(MAX_PROCS);
    localparam int PCNT_BITS = $clog2(MAX_PROCS + 1);

    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CFG_IDX_BITS-1:0] CFG_TOTAL_MEMORY = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BLOCK_COUNT  = 2'd1;

    localparam logic [6:0] BLOCK_COUNT_RESET = 7'd64;

    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_ALLOC   = 2'd1;
    localparam logic [1:0] OP_RELEASE = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOFIT  = 2'd1;
    localparam logic [1:0] ST_NOLIVE = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    typedef struct packed {
        logic capture;     // latch input word
        logic scan_start;  // clear worst-fit search
        logic scan_rd;     // read next partition size
        logic rel_rd;      // read process table entry
        logic commit;      // apply item, load result register
        logic rc_step;     // one step of free partition recount
        logic cfg_we;      // config write
    } wfpa_cmd_t;

    typedef struct packed {
        logic full;
        logic scan_last;
        logic rc_last;
    } wfpa_sts_t;

    // block_count of 0 counts as 1, above MAX_PARTS as MAX_PARTS
    function automatic logic [CNT_BITS-1:0] used_parts(input logic [6:0] bc);
        logic [CNT_BITS-1:0] n;
        if (bc == 7'd0) begin
            n = CNT_BITS'(1);
        end else if (int'(bc) > MAX_PARTS) begin
            n = CNT_BITS'(MAX_PARTS);
        end else begin
            n = CNT_BITS'(bc);
        end
        return n;
    endfunction

endpackage

// ----- sv/wfpa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wfpa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- sv/wfpa_ctrl.sv -----
// Controller for the worst-fit partition allocator: item sequencing,
// partition scan, recount sweep and result handshake. Uses wfpa_pkg.
module wfpa_ctrl (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [1:0]                           s_operation,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [wfpa_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  wfpa_pkg::wfpa_sts_t                  sts,
    output wfpa_pkg::wfpa_cmd_t                  cmd
);
    import wfpa_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_LAST,
        S_REL,
        S_COMMIT,
        S_RECOUNT
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   in_acc, cfg_acc, out_free;

    // config write wins over an input word in the same cycle
    assign s_ready   = (state_reg == S_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg == S_IDLE);
    assign m_valid   = m_valid_reg;

    assign in_acc   = s_valid && s_ready;
    assign cfg_acc  = cfg_valid && cfg_ready;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        cmd.capture    = in_acc;
        cmd.scan_start = in_acc && (s_operation == OP_ALLOC) && !sts.full;
        cmd.scan_rd    = (state_reg == S_SCAN);
        cmd.rel_rd     = (state_reg == S_REL);
        cmd.commit     = (state_reg == S_COMMIT) && out_free;
        cmd.rc_step    = (state_reg == S_RECOUNT);
        cmd.cfg_we     = cfg_acc;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_acc) begin
                    if (cmd.scan_start) begin
                        state_next = S_SCAN;
                    end else if (s_operation == OP_RELEASE) begin
                        state_next = S_REL;
                    end else begin
                        state_next = S_COMMIT;
                    end
                end else if (cfg_acc && cfg_index == CFG_BLOCK_COUNT) begin
                    state_next = S_RECOUNT;
                end
            end
            S_SCAN: begin
                if (sts.scan_last) begin
                    state_next = S_LAST;
                end
            end
            S_LAST:   state_next = S_COMMIT;
            S_REL:    state_next = S_COMMIT;
            S_COMMIT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            S_RECOUNT: begin
                if (sts.rc_last) begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb begin
        if (cmd.commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ----- sv/wfpa_dp.sv -----
// Datapath for the worst-fit partition allocator: partition and process
// tables, worst-fit search, free memory/partition bookkeeping, result word.
// Uses wfpa_pkg and wfpa_ram.
module wfpa_dp (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  wfpa_pkg::wfpa_cmd_t                  cmd,
    output wfpa_pkg::wfpa_sts_t                  sts,
    input  logic [wfpa_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [wfpa_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic [1:0]                           s_operation,
    input  logic [5:0]                           s_part_index,
    input  logic [15:0]                          s_part_size,
    input  logic [15:0]                          s_request_size,
    input  logic [7:0]                           s_process_number,
    output logic [1:0]                           m_status,
    output logic [5:0]                           m_granted_part,
    output logic [7:0]                           m_assigned_process,
    output logic [15:0]                          m_free_memory,
    output logic [6:0]                           m_free_parts
);
    import wfpa_pkg::*;

    localparam int PROC_W = PART_BITS + SIZE_BITS;

    // captured input word
    logic [1:0]  op_reg;
    logic [5:0]  pidx_reg;
    logic [15:0] psize_reg;
    logic [15:0] req_reg;
    logic [7:0]  pnum_reg;

    logic [CNT_BITS-1:0]  n_reg, n_next;
    logic [SIZE_BITS-1:0] free_mem_reg, free_mem_next;
    logic [CNT_BITS-1:0]  free_cnt_reg, free_cnt_next;
    logic [PCNT_BITS-1:0] pctr_reg, pctr_next;
    logic [MAX_PARTS-1:0] busy_reg;
    logic [MAX_PROCS-1:0] live_reg;

    logic [PART_BITS-1:0] scan_idx_reg, scan_idx_next;
    logic                 rd_vld_reg;
    logic [PART_BITS-1:0] rd_idx_reg;
    logic                 found_reg, found_next;
    logic [PART_BITS-1:0] best_reg, best_next;
    logic [SIZE_BITS-1:0] bsize_reg, bsize_next;
    logic [PART_BITS-1:0] rc_idx_reg, rc_idx_next;

    logic [1:0]  status_reg, status_next;
    logic [5:0]  granted_reg, granted_next;
    logic [7:0]  assigned_reg, assigned_next;
    logic [15:0] fmem_out_reg;
    logic [6:0]  fcnt_out_reg;

    logic [SIZE_BITS-1:0] part_rd;
    logic [PROC_W-1:0]    proc_rd;
    logic                 part_we, proc_we;
    logic [SIZE_BITS-1:0] req_s;
    logic [PART_BITS-1:0] rel_part;
    logic [SIZE_BITS-1:0] rel_size;
    logic [SIZE_BITS:0]   rel_sum;
    logic                 fits, rel_ok, cand;
    logic                 busy_set, busy_clr, live_set, live_clr;
    logic [PART_BITS-1:0] n_last;

    assign req_s    = SIZE_BITS'(req_reg);
    assign rel_part = proc_rd[PROC_W-1:SIZE_BITS];
    assign rel_size = proc_rd[SIZE_BITS-1:0];
    assign rel_sum  = {1'b0, free_mem_reg} + {1'b0, rel_size};
    assign n_last   = PART_BITS'(n_reg - CNT_BITS'(1));

    assign sts.full      = (int'(pctr_reg) >= MAX_PROCS);
    assign sts.scan_last = (scan_idx_reg == n_last);
    assign sts.rc_last   = (rc_idx_reg == n_last);

    assign fits   = found_reg && (bsize_reg >= req_s);
    assign rel_ok = (pnum_reg < pctr_reg) && (int'(pnum_reg) < MAX_PROCS)
                    && live_reg[PROC_BITS'(pnum_reg)];
    assign part_we = cmd.commit && (op_reg == OP_LOAD) && (pidx_reg < n_reg);

    wfpa_ram #(
        .WIDTH (SIZE_BITS),
        .DEPTH (MAX_PARTS)
    ) u_part_ram (
        .aclk    (aclk),
        .wr_en   (part_we),
        .wr_addr (PART_BITS'(pidx_reg)),
        .wr_data (SIZE_BITS'(psize_reg)),
        .rd_en   (cmd.scan_rd),
        .rd_addr (scan_idx_reg),
        .rd_data (part_rd)
    );

    wfpa_ram #(
        .WIDTH (PROC_W),
        .DEPTH (MAX_PROCS)
    ) u_proc_ram (
        .aclk    (aclk),
        .wr_en   (proc_we),
        .wr_addr (PROC_BITS'(pctr_reg)),
        .wr_data ({best_reg, req_s}),
        .rd_en   (cmd.rel_rd),
        .rd_addr (PROC_BITS'(pnum_reg)),
        .rd_data (proc_rd)
    );

    // worst-fit search: one size per cycle, strict > keeps lowest index on ties
    assign cand = rd_vld_reg && !busy_reg[rd_idx_reg]
                  && (!found_reg || part_rd > bsize_reg);

    always_comb begin
        scan_idx_next = scan_idx_reg;
        found_next    = found_reg;
        best_next     = best_reg;
        bsize_next    = bsize_reg;
        if (cmd.scan_start) begin
            scan_idx_next = '0;
            found_next    = 1'b0;
        end else begin
            if (cmd.scan_rd) begin
                scan_idx_next = scan_idx_reg + PART_BITS'(1);
            end
            if (cand) begin
                found_next = 1'b1;
                best_next  = rd_idx_reg;
                bsize_next = part_rd;
            end
        end
    end

    always_comb begin
        n_next        = n_reg;
        free_mem_next = free_mem_reg;
        free_cnt_next = free_cnt_reg;
        pctr_next     = pctr_reg;
        rc_idx_next   = rc_idx_reg;
        status_next   = ST_OK;
        granted_next  = '0;
        assigned_next = '0;
        busy_set      = 1'b0;
        busy_clr      = 1'b0;
        live_set      = 1'b0;
        live_clr      = 1'b0;
        proc_we       = 1'b0;

        if (cmd.commit) begin
            case (op_reg)
                OP_LOAD: begin
                    granted_next = pidx_reg;
                end
                OP_ALLOC: begin
                    if (sts.full) begin
                        status_next = ST_FULL;
                    end else begin
                        assigned_next = 8'(pctr_reg);
                        pctr_next     = pctr_reg + PCNT_BITS'(1);
                        if (fits) begin
                            busy_set      = 1'b1;
                            live_set      = 1'b1;
                            proc_we       = 1'b1;
                            free_mem_next = (free_mem_reg >= req_s) ?
                                            free_mem_reg - req_s : '0;
                            free_cnt_next = free_cnt_reg - CNT_BITS'(1);
                            granted_next  = 6'(best_reg);
                        end else begin
                            status_next = ST_NOFIT;
                        end
                    end
                end
                OP_RELEASE: begin
                    if (rel_ok) begin
                        busy_clr      = 1'b1;
                        live_clr      = 1'b1;
                        free_mem_next = rel_sum[SIZE_BITS] ? '1 :
                                        rel_sum[SIZE_BITS-1:0];
                        // only partitions inside block_count are counted
                        if ((rel_part < n_reg) && busy_reg[rel_part]) begin
                            free_cnt_next = free_cnt_reg + CNT_BITS'(1);
                        end
                        granted_next = 6'(rel_part);
                    end else begin
                        status_next = ST_NOLIVE;
                    end
                end
                default: ;
            endcase
        end

        if (cmd.cfg_we) begin
            case (cfg_index)
                CFG_TOTAL_MEMORY: free_mem_next = SIZE_BITS'(cfg_data);
                CFG_BLOCK_COUNT: begin
                    n_next        = used_parts(cfg_data[6:0]);
                    free_cnt_next = '0;
                    rc_idx_next   = '0;
                end
                default: ;
            endcase
        end

        if (cmd.rc_step) begin
            free_cnt_next = free_cnt_reg + CNT_BITS'(!busy_reg[rc_idx_reg]);
            rc_idx_next   = rc_idx_reg + PART_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_reg        <= used_parts(BLOCK_COUNT_RESET);
            free_mem_reg <= '0;
            free_cnt_reg <= used_parts(BLOCK_COUNT_RESET);
            pctr_reg     <= '0;
            busy_reg     <= '0;
            live_reg     <= '0;
            rd_vld_reg   <= 1'b0;
            found_reg    <= 1'b0;
        end else begin
            n_reg        <= n_next;
            free_mem_reg <= free_mem_next;
            free_cnt_reg <= free_cnt_next;
            pctr_reg     <= pctr_next;
            rd_vld_reg   <= cmd.scan_rd;
            found_reg    <= found_next;
            if (busy_set) begin
                busy_reg[best_reg] <= 1'b1;
            end
            if (busy_clr) begin
                busy_reg[rel_part] <= 1'b0;
            end
            if (live_set) begin
                live_reg[PROC_BITS'(pctr_reg)] <= 1'b1;
            end
            if (live_clr) begin
                live_reg[PROC_BITS'(pnum_reg)] <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        scan_idx_reg <= scan_idx_next;
        rd_idx_reg   <= scan_idx_reg;
        best_reg     <= best_next;
        bsize_reg    <= bsize_next;
        rc_idx_reg   <= rc_idx_next;
        if (cmd.capture) begin
            op_reg    <= s_operation;
            pidx_reg  <= s_part_index;
            psize_reg <= s_part_size;
            req_reg   <= s_request_size;
            pnum_reg  <= s_process_number;
        end
        if (cmd.commit) begin
            status_reg   <= status_next;
            granted_reg  <= granted_next;
            assigned_reg <= assigned_next;
            fmem_out_reg <= 16'(free_mem_next);
            fcnt_out_reg <= 7'(free_cnt_next);
        end
    end

    assign m_status           = status_reg;
    assign m_granted_part     = granted_reg;
    assign m_assigned_process = assigned_reg;
    assign m_free_memory      = fmem_out_reg;
    assign m_free_parts       = fcnt_out_reg;

endmodule

// ----- sv/worst_fit_partition_allocator.sv -----
// Worst-fit fixed-partition allocator, top level. Uses wfpa_pkg, wfpa_ctrl, wfpa_dp.
// An allocate that is not table-full first scans block_count partition sizes, one size
// read per cycle; a release first reads the process table entry of its process number.
// One word in flight; the next word is taken once the result is in the output register.
// A block_count write recounts, one partition per cycle.
// Reset (aresetn low, synchronous): all partitions free, no live process, free memory 0.
module worst_fit_partition_allocator (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [1:0]                           s_operation,
    input  logic [5:0]                           s_part_index,
    input  logic [15:0]                          s_part_size,
    input  logic [15:0]                          s_request_size,
    input  logic [7:0]                           s_process_number,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [1:0]                           m_status,
    output logic [5:0]                           m_granted_part,
    output logic [7:0]                           m_assigned_process,
    output logic [15:0]                          m_free_memory,
    output logic [6:0]                           m_free_parts,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [wfpa_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [wfpa_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import wfpa_pkg::*;

    wfpa_cmd_t cmd;
    wfpa_sts_t sts;

    wfpa_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .sts         (sts),
        .cmd         (cmd)
    );

    wfpa_dp u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .sts                (sts),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .s_operation        (s_operation),
        .s_part_index       (s_part_index),
        .s_part_size        (s_part_size),
        .s_request_size     (s_request_size),
        .s_process_number   (s_process_number),
        .m_status           (m_status),
        .m_granted_part     (m_granted_part),
        .m_assigned_process (m_assigned_process),
        .m_free_memory      (m_free_memory),
        .m_free_parts       (m_free_parts)
    );

`ifndef ASSERT_OFF
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while previous word still in work");

    a_result_from_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(cmd.commit))
        else $error("result valid without commit");

    a_full_no_process: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_FULL |-> m_assigned_process == 8'd0)
        else $error("table full result carries a process number");

    a_nofit_no_part: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_NOFIT |-> m_granted_part == 6'd0)
        else $error("failed allocate carries a partition");
`endif

endmodule
